/* hdl/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
// Event codes, register indexes, reset values and the threshold bundle.
// No dependencies.
package bcc_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned ThrW   = 16;
	localparam int unsigned EventW = 2;
	localparam int unsigned IdxW   = 2;

	// event codes
	localparam logic [EventW-1:0] EV_IDLE   = 2'd0;
	localparam logic [EventW-1:0] EV_SHORT  = 2'd1;
	localparam logic [EventW-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EventW-1:0] EV_LONG   = 2'd3;

	// register indexes
	localparam logic [IdxW-1:0] REG_SHORT    = 2'd0;
	localparam logic [IdxW-1:0] REG_DOUBLE   = 2'd1;
	localparam logic [IdxW-1:0] REG_LONG     = 2'd2;
	localparam logic [IdxW-1:0] REG_DEBOUNCE = 2'd3;

	// reset values
	localparam logic [ThrW-1:0] SHORT_RST    = 16'd300;
	localparam logic [ThrW-1:0] DOUBLE_RST   = 16'd400;
	localparam logic [ThrW-1:0] LONG_RST     = 16'd1000;
	localparam logic [ThrW-1:0] DEBOUNCE_RST = 16'd50;

	typedef struct packed {
		logic [ThrW-1:0] short_click_ms;
		logic [ThrW-1:0] double_click_ms;
		logic [ThrW-1:0] long_click_ms;
		logic [ThrW-1:0] debounce_ms;
	} cfg_t;

endpackage

/* hdl/bcc_cfg.sv */
// Threshold register file of the button click classifier.
// Depends on bcc_pkg.
module bcc_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [bcc_pkg::IdxW-1:0] cfg_index,
	input  logic [bcc_pkg::ThrW-1:0] cfg_data,
	output bcc_pkg::cfg_t           cfg
);
	import bcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_click_ms  <= SHORT_RST;
			cfg_q.double_click_ms <= DOUBLE_RST;
			cfg_q.long_click_ms   <= LONG_RST;
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SHORT:    cfg_q.short_click_ms  <= cfg_data;
				REG_DOUBLE:   cfg_q.double_click_ms <= cfg_data;
				REG_LONG:     cfg_q.long_click_ms   <= cfg_data;
				REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/bcc_core.sv */
// Debounce and click classification state with its update logic.
// Produces one event code per sample; state advances on fire.
// Depends on bcc_pkg.
module bcc_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic                      level,
	input  logic [bcc_pkg::TimeW-1:0] now,
	input  bcc_pkg::cfg_t             cfg,
	output logic [bcc_pkg::EventW-1:0] ev
);
	import bcc_pkg::*;

	logic             is_pressed_q;
	logic [TimeW-1:0] press_time_q;
	logic [TimeW-1:0] release_time_q;
	logic [TimeW-1:0] click_time_q;
	logic [TimeW-1:0] double_time_q;
	logic             pend_click_q;
	logic             pend_double_q;
	logic             pend_long_q;

	logic [TimeW-1:0] since_press;
	logic [TimeW-1:0] since_release;
	logic [TimeW-1:0] since_click;
	logic [TimeW-1:0] since_double;
	logic [ThrW:0]    dbl_gap;
	logic             press_ok;
	logic             rel_ok;
	logic             is_short;
	logic             is_long;
	logic             dbl_ok;
	logic             pc_set;
	logic             pd_set;
	logic             pl_set;
	logic [TimeW-1:0] rel_time_nx;
	logic [TimeW-1:0] since_rel_nx;
	logic             pc_nx;
	logic             pd_nx;
	logic             pl_nx;

	always_comb begin
		since_press   = now - press_time_q;
		since_release = now - release_time_q;
		since_click   = now - click_time_q;
		since_double  = now - double_time_q;
		dbl_gap       = {1'b0, cfg.short_click_ms} + {1'b0, cfg.double_click_ms};

		press_ok = level && !is_pressed_q
			&& (since_press > {{(TimeW-ThrW){1'b0}}, cfg.debounce_ms});
		rel_ok   = !level && is_pressed_q
			&& (since_release > {{(TimeW-ThrW){1'b0}}, cfg.debounce_ms});

		// press length equals since_press once the release time is now
		is_short = since_press < {{(TimeW-ThrW){1'b0}}, cfg.short_click_ms};
		is_long  = since_press > {{(TimeW-ThrW){1'b0}}, cfg.long_click_ms};
		dbl_ok   = (since_click < {{(TimeW-ThrW){1'b0}}, cfg.double_click_ms})
			&& (since_double > {{(TimeW-ThrW-1){1'b0}}, dbl_gap});

		pc_set = rel_ok && is_short;
		pd_set = pc_set && dbl_ok;
		pl_set = rel_ok && !is_short && is_long;

		rel_time_nx  = rel_ok ? now : release_time_q;
		since_rel_nx = now - rel_time_nx;

		pc_nx = pend_click_q || pc_set;
		pd_nx = pend_double_q || pd_set;
		pl_nx = pend_long_q || pl_set;

		// double wins, then short once the double window has closed, then long
		if (pc_nx && pd_nx) begin
			ev    = EV_DOUBLE;
			pc_nx = 1'b0;
			pd_nx = 1'b0;
		end else if (pc_nx
				&& (since_rel_nx > {{(TimeW-ThrW){1'b0}}, cfg.double_click_ms})) begin
			ev    = EV_SHORT;
			pc_nx = 1'b0;
		end else if (pl_nx) begin
			ev    = EV_LONG;
			pl_nx = 1'b0;
		end else begin
			ev = EV_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q   <= 1'b0;
			press_time_q   <= '0;
			release_time_q <= '0;
			click_time_q   <= '0;
			double_time_q  <= '0;
			pend_click_q   <= 1'b0;
			pend_double_q  <= 1'b0;
			pend_long_q    <= 1'b0;
		end else if (fire) begin
			if (press_ok) begin
				is_pressed_q <= 1'b1;
				press_time_q <= now;
			end
			if (rel_ok) begin
				is_pressed_q <= 1'b0;
			end
			release_time_q <= rel_time_nx;
			if (pc_set) begin
				click_time_q <= now;
			end
			if (pd_set) begin
				double_time_q <= now;
			end
			pend_click_q  <= pc_nx;
			pend_double_q <= pd_nx;
			pend_long_q   <= pl_nx;
		end
	end

endmodule

/* hdl/button_click_classifier.sv */
// Top level of the button click classifier: sample register, classifier
// state and result register. Depends on bcc_pkg, bcc_cfg and bcc_core.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, button_level, now_ms | sample in
//   out     | out_valid, out_stall, event_code | event out
//   cfg     | cfg_wr_en, cfg_index, cfg_data   | threshold write
//
// One sample per cycle while the output is not stalled; a sample passes
// through the sample register, then the result register, to a valid result.
// Classifier state advances when a sample moves from the sample register
// into the result register, so each sample sees the state its predecessor left.
// A stalled result holds; a full sample register then holds too and in_stall rises.
// Reset clears valids, state and thresholds to their default values.
module button_click_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       button_level,
	input  logic [bcc_pkg::TimeW-1:0]  now_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bcc_pkg::EventW-1:0] event_code,
	input  logic                       cfg_wr_en,
	input  logic [bcc_pkg::IdxW-1:0]   cfg_index,
	input  logic [bcc_pkg::ThrW-1:0]   cfg_data
);
	import bcc_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic              level_s1;
	logic [TimeW-1:0]  now_s1;
	logic              out_valid_q;
	logic [EventW-1:0] event_q;
	logic [EventW-1:0] ev;
	logic              out_free;
	logic              fire;
	logic              s1_free;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;

	bcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.level  (level_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			level_s1 <= button_level;
			now_s1   <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// load the result only on a transfer out of the sample register
	always_ff @(posedge clk) begin
		if (fire) begin
			event_q <= ev;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

endmodule

/* hdl/bcc_check.sv */
// Port-level checks for the button click classifier, bound to the top level.
// Depends on bcc_pkg and button_click_classifier.
module bcc_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [bcc_pkg::EventW-1:0] event_code
);
	import bcc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code))
		else $error("stalled result changed");

	// input only stalls when the result register is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output can drain");

	// a sample that enters with both stages empty yields a result via both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && !$past(in_valid && !in_stall)
		|=> ##1 out_valid)
		else $error("accepted sample produced no result");

endmodule

bind button_click_classifier bcc_check u_bcc_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_code (event_code)
);

/* tb/tb_button_click_classifier.sv */
// Testbench for button_click_classifier: drives button samples through the
// valid/stall channels, predicts every event code and checks it on transfer.
// Depends on bcc_pkg and the button_click_classifier RTL.
module tb_button_click_classifier;
	import bcc_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned PhaseItems = 100;

	// Expected event codes plus a private copy of the classifier state.
	class click_scoreboard;
		logic [EventW-1:0] expected_events[$];
		int unsigned errors;
		bit [ThrW-1:0] short_ms, double_ms, long_ms, debounce_ms;
		bit pressed, click_armed, double_armed, long_armed;
		bit [TimeW-1:0] press_at, release_at, click_at, double_at;

		function new();
			short_ms = SHORT_RST;
			double_ms = DOUBLE_RST;
			long_ms = LONG_RST;
			debounce_ms = DEBOUNCE_RST;
		endfunction

		function void set_threshold(logic [IdxW-1:0] idx, bit [ThrW-1:0] value);
			case (idx)
				REG_SHORT:    short_ms = value;
				REG_DOUBLE:   double_ms = value;
				REG_LONG:     long_ms = value;
				REG_DEBOUNCE: debounce_ms = value;
				default: ;
			endcase
		endfunction

		function bit [TimeW-1:0] since(bit [TimeW-1:0] now, bit [TimeW-1:0] then_ms);
			return now - then_ms;
		endfunction

		function void note_sample(bit level, bit [TimeW-1:0] now);
			bit [TimeW-1:0] held;
			bit [ThrW:0] pair_span;
			logic [EventW-1:0] ev;
			pair_span = {1'b0, short_ms} + {1'b0, double_ms};
			if (level) begin
				if (!pressed && since(now, press_at) > debounce_ms) begin
					press_at = now;
					pressed = 1'b1;
				end
			end else if (pressed && since(now, release_at) > debounce_ms) begin
				release_at = now;
				held = since(release_at, press_at);
				if (held < short_ms) begin
					if (since(now, click_at) < double_ms && since(now, double_at) > pair_span) begin
						double_armed = 1'b1;
						double_at = now;
					end
					click_armed = 1'b1;
					click_at = now;
				end else if (held > long_ms) begin
					long_armed = 1'b1;
				end
				pressed = 1'b0;
			end
			// double wins over short, short over long
			if (click_armed && double_armed) begin
				ev = EV_DOUBLE;
				click_armed = 1'b0;
				double_armed = 1'b0;
			end else if (click_armed && since(now, release_at) > double_ms) begin
				ev = EV_SHORT;
				click_armed = 1'b0;
			end else if (long_armed) begin
				ev = EV_LONG;
				long_armed = 1'b0;
			end else begin
				ev = EV_IDLE;
			end
			expected_events.push_back(ev);
		endfunction

		function void check_event(logic [EventW-1:0] got);
			logic [EventW-1:0] want;
			if (expected_events.size() == 0) begin
				$error("event_code: unexpected result, expected none, actual %0d", got);
				errors++;
			end else begin
				want = expected_events.pop_front();
				if (got !== want) begin
					$error("event_code: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic button_level = 1'b0;
	logic [TimeW-1:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [EventW-1:0] event_code;
	logic cfg_wr_en = 1'b0;
	logic [IdxW-1:0] cfg_index = REG_SHORT;
	logic [ThrW-1:0] cfg_data = '0;

	click_scoreboard sb;
	bit [TimeW-1:0] clock_ms;
	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned cycles;
	int unsigned stall_mode;
	int unsigned stall_count;

	button_click_classifier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.button_level(button_level),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_code(event_code),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: stall pattern switches at random among four modes
	always @(posedge clk) begin
		stall_count++;
		if (stall_count % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (stall_count % 5 < 2);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_event(event_code);
	end

	// Present one sample and hold it until the transfer; valid stays high
	// inside a burst so the caller must present the next sample right away.
	task automatic drive_sample(bit level, bit [TimeW-1:0] t);
		in_valid <= 1'b1;
		button_level <= level;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		sb.note_sample(level, t);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 12);
		end
	endtask

	// Drop valid and wait until every event has come out.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IdxW-1:0] idx, bit [ThrW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_threshold(idx, value);
	endtask

	task automatic program_thresholds(bit [ThrW-1:0] s, bit [ThrW-1:0] d,
			bit [ThrW-1:0] l, bit [ThrW-1:0] db);
		write_reg(REG_SHORT, s);
		write_reg(REG_DOUBLE, d);
		write_reg(REG_LONG, l);
		write_reg(REG_DEBOUNCE, db);
		cfg_wr_en <= 1'b0;
	endtask

	// One press and release with random spacing, plus bounce and noise.
	task automatic press_and_release();
		int unsigned sc, dw, lg, db, held;
		bit [TimeW-1:0] pressed_at;
		sc = int'(sb.short_ms);
		dw = int'(sb.double_ms);
		lg = int'(sb.long_ms);
		db = int'(sb.debounce_ms);
		case ($urandom_range(0, 19))
			0: clock_ms = $urandom();
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * lg + 100);
			2, 3: begin
				repeat ($urandom_range(1, 5)) begin
					clock_ms += $urandom_range(0, 2 * db + 2);
					drive_sample(1'($urandom_range(0, 1)), clock_ms);
				end
			end
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0, 1: clock_ms += $urandom_range(0, dw);
			2: clock_ms += db + 1;
			3: clock_ms += $urandom_range(0, db);
			4: clock_ms += sc + dw + $urandom_range(0, dw + 10);
			default: clock_ms += $urandom_range(0, 200000);
		endcase
		drive_sample(1'b1, clock_ms);
		pressed_at = clock_ms;
		case ($urandom_range(0, 6))
			0, 1: held = $urandom_range(0, (sc > 0) ? sc - 1 : 0);
			2: held = sc;
			3: held = lg;
			4: held = lg + 1;
			5: held = $urandom_range(lg + 1, lg + 3000);
			default: held = $urandom_range(sc, lg);
		endcase
		// contact bounce right after the press
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				drive_sample(1'($urandom_range(0, 1)),
					pressed_at + $urandom_range(0, db + 1));
		repeat ($urandom_range(0, 2))
			drive_sample(1'b1, pressed_at + $urandom_range(0, held));
		clock_ms = pressed_at + held;
		drive_sample(1'b0, clock_ms);
		repeat ($urandom_range(0, 2)) begin
			clock_ms += $urandom_range(0, dw + 1);
			drive_sample(1'b0, clock_ms);
		end
	endtask

	task automatic run_items(int unsigned count);
		int unsigned target;
		target = items_sent + count;
		while (items_sent < target)
			press_and_release();
	endtask

	initial begin
		sb = new();
		stall_mode = 0;
		burst_left = 8;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: 300 / 400 / 1000 / 50
		drive_sample(1'b0, 32'd0);
		drive_sample(1'b1, 32'd32);          // press inside debounce
		drive_sample(1'b1, 32'd1000);
		drive_sample(1'b0, 32'd1100);
		drive_sample(1'b0, 32'd1600);        // short click comes out
		drive_sample(1'b1, 32'd2000);
		drive_sample(1'b0, 32'd2100);
		drive_sample(1'b1, 32'd2200);
		drive_sample(1'b0, 32'd2300);        // double click
		drive_sample(1'b1, 32'd2330);
		drive_sample(1'b0, 32'd2340);        // release inside debounce
		drive_sample(1'b0, 32'd2400);        // click too soon after a double
		drive_sample(1'b1, 32'd3000);
		drive_sample(1'b1, 32'd3500);
		drive_sample(1'b0, 32'd4200);        // long click
		drive_sample(1'b1, 32'd5000);
		drive_sample(1'b0, 32'd5300);        // press exactly at the short bound
		drive_sample(1'b1, 32'd6000);
		drive_sample(1'b0, 32'd7000);        // press exactly at the long bound
		drive_sample(1'b1, 32'hFFFF_FF00);
		drive_sample(1'b0, 32'hFFFF_FFFF);
		drive_sample(1'b1, 32'h0000_0050);   // across the counter wrap
		drive_sample(1'b0, 32'h0000_00A0);
		drive_sample(1'b0, 32'h0000_0400);
		clock_ms = 32'h0000_2000;
		run_items(PhaseItems);

		for (int p = 1; p < 7; p++) begin
			settle_block();
			case (p)
				1: program_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
				2: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: program_thresholds(16'd20, 16'd30, 16'd60, 16'd3);
				4: program_thresholds(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
				5: program_thresholds(ThrW'($urandom_range(0, 2000)),
					ThrW'($urandom_range(0, 2000)),
					ThrW'($urandom_range(0, 4000)), ThrW'($urandom_range(0, 200)));
				default: program_thresholds(SHORT_RST, DOUBLE_RST, LONG_RST, DEBOUNCE_RST);
			endcase
			run_items(PhaseItems);
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_events.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
